@@ hdl/rpv_pkg.sv @@
// Shared types, codes and constants of the relative path validator.
package rpv_pkg;

    // Default limits (module parameters take these)
    localparam int unsigned PATH_LENGTH_LIMIT      = 4096;
    localparam int unsigned COMPONENT_LENGTH_LIMIT = 255;

    // Compare widths that cover the whole parameter range plus saturation
    localparam int unsigned PATH_CMP_W = 17;
    localparam int unsigned COMP_CMP_W = 13;

    localparam int unsigned MAX_PATH_W = 13;
    localparam int unsigned MAX_COMP_W = 8;
    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [MAX_PATH_W-1:0] MAX_PATH_RESET = 13'd4096;
    localparam logic [MAX_COMP_W-1:0] MAX_COMP_RESET = 8'd255;

    typedef enum logic [0:0] {
        CFG_MAX_PATH = 1'b0,
        CFG_MAX_COMP = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_EMPTY      = 3'd1,
        STATUS_TOO_LONG   = 3'd2,
        STATUS_ABSOLUTE   = 3'd3,
        STATUS_FORBIDDEN  = 3'd4,
        STATUS_EMPTY_COMP = 3'd5,
        STATUS_DOT_COMP   = 3'd6,
        STATUS_LONG_COMP  = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        DOT_NONE  = 2'd0,
        DOT_ONE   = 2'd1,
        DOT_TWO   = 2'd2,
        DOT_OTHER = 2'd3
    } dot_t;

    typedef enum logic [1:0] {
        CERR_NONE  = 2'd0,
        CERR_EMPTY = 2'd1,
        CERR_DOT   = 2'd2,
        CERR_LONG  = 2'd3
    } cerr_t;

    localparam logic [7:0] CHAR_CTRL_END  = 8'h20;
    localparam logic [7:0] CHAR_DEL       = 8'h7f;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_COLON     = 8'h3a;
    localparam logic [7:0] CHAR_SLASH     = 8'h2f;
    localparam logic [7:0] CHAR_DOT       = 8'h2e;

endpackage

@@ hdl/rpv_if.sv @@
// Valid/ready channel interfaces for path bytes and status results.
interface rpv_path_if;
    logic       valid;
    logic       ready;
    logic [7:0] path_byte;
    logic       last;
    logic       no_byte;

    modport source (output valid, output path_byte, output last, output no_byte, input ready);
    modport sink   (input valid, input path_byte, input last, input no_byte, output ready);
endinterface

interface rpv_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

@@ hdl/rpv_comp_check.sv @@
// Error classification of one closed path component.
module rpv_comp_check
(
    input  logic [rpv_pkg::COMP_CMP_W-1:0] count,
    input  rpv_pkg::dot_t                  dot,
    input  logic [rpv_pkg::COMP_CMP_W-1:0] limit,
    output rpv_pkg::cerr_t                 cerr
);
    import rpv_pkg::*;

    always_comb
    begin
        priority if (count == '0)
        begin
            cerr = CERR_EMPTY;
        end
        else if (dot == DOT_ONE || dot == DOT_TWO)
        begin
            cerr = CERR_DOT;
        end
        else if (count > limit)
        begin
            cerr = CERR_LONG;
        end
        else
        begin
            cerr = CERR_NONE;
        end
    end

endmodule

@@ hdl/relative_path_validator.sv @@
// Top level of the relative path validator: byte classifier, counters, status register.
//
//  channel | dir | handshake   | payload
//  path    | in  | valid/ready | path_byte[7:0], last, no_byte
//  result  | out | valid/ready | status[2:0]
//  cfg     | in  | cfg_we      | cfg_index[0], cfg_data[12:0]
//
// One byte per cycle while path.ready is high; the status of a path is in the result
// register in the cycle after its last request is taken.
// path.ready is low only while a status waits and result.ready is low.
// Reset (rst_n, async, active low) clears the path state and the result valid
// flag (not the status value) and loads the limit registers with their defaults.
module relative_path_validator
#(
    parameter int unsigned PATH_LIMIT = rpv_pkg::PATH_LENGTH_LIMIT,
    parameter int unsigned COMP_LIMIT = rpv_pkg::COMPONENT_LENGTH_LIMIT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  rpv_pkg::cfg_index_t           cfg_index,
    input  logic [rpv_pkg::CFG_DATA_W-1:0] cfg_data,
    rpv_path_if.sink                      path,
    rpv_result_if.source                  result
);
    import rpv_pkg::*;

    localparam int unsigned TW = $clog2(PATH_LIMIT + 2);
    localparam int unsigned CW = $clog2(COMP_LIMIT + 2);
    localparam logic [TW-1:0] TOT_SAT  = TW'(PATH_LIMIT + 1);
    localparam logic [CW-1:0] COMP_SAT = CW'(COMP_LIMIT + 1);

    logic [MAX_PATH_W-1:0] max_path_reg;
    logic [MAX_COMP_W-1:0] max_comp_reg;

    logic [TW-1:0] tot_reg, tot_next;
    logic [CW-1:0] comp_reg, comp_next;
    dot_t          dot_reg, dot_next;
    logic          start_reg, start_next;
    logic          slash_first_reg, slash_first_next;
    logic          forb_reg, forb_next;
    cerr_t         first_err_reg, first_err_next;

    logic    out_valid_reg;
    status_t status_reg, status_next;

    logic accept;
    logic byte_in;
    logic is_slash;
    logic is_forbidden;
    logic [COMP_CMP_W-1:0] comp_lim;
    logic [PATH_CMP_W-1:0] path_lim;
    cerr_t slash_err, end_err, final_err;

    assign path.ready    = !out_valid_reg || result.ready;
    assign accept        = path.valid && path.ready;
    assign result.valid  = out_valid_reg;
    assign result.status = status_reg;

    assign byte_in      = !path.no_byte;
    assign is_slash     = path.path_byte == CHAR_SLASH;
    assign is_forbidden = path.path_byte < CHAR_CTRL_END || path.path_byte == CHAR_DEL
                          || path.path_byte == CHAR_BACKSLASH || path.path_byte == CHAR_COLON;

    // limit in use is the smaller of register and parameter
    always_comb
    begin
        comp_lim = COMP_CMP_W'(max_comp_reg);
        if (COMP_CMP_W'(COMP_LIMIT) < comp_lim)
        begin
            comp_lim = COMP_CMP_W'(COMP_LIMIT);
        end
        path_lim = PATH_CMP_W'(max_path_reg);
        if (PATH_CMP_W'(PATH_LIMIT) < path_lim)
        begin
            path_lim = PATH_CMP_W'(PATH_LIMIT);
        end
    end

    // component closed by a slash byte
    rpv_comp_check u_slash_check
    (
        .count (COMP_CMP_W'(comp_reg)),
        .dot   (dot_reg),
        .limit (comp_lim),
        .cerr  (slash_err)
    );

    // component closed by the end of the path
    rpv_comp_check u_end_check
    (
        .count (COMP_CMP_W'(comp_next)),
        .dot   (dot_next),
        .limit (comp_lim),
        .cerr  (end_err)
    );

    always_comb
    begin
        start_next       = start_reg && !byte_in;
        slash_first_next = (start_reg && byte_in) ? is_slash : slash_first_reg;
        tot_next         = (byte_in && tot_reg != TOT_SAT) ? tot_reg + TW'(1) : tot_reg;
        forb_next        = forb_reg || (byte_in && is_forbidden);
        first_err_next   = first_err_reg;
        comp_next        = comp_reg;
        dot_next         = dot_reg;
        if (byte_in)
        begin
            if (is_slash)
            begin
                if (first_err_reg == CERR_NONE)
                begin
                    first_err_next = slash_err;
                end
                comp_next = '0;
                dot_next  = DOT_NONE;
            end
            else
            begin
                if (comp_reg != COMP_SAT)
                begin
                    comp_next = comp_reg + CW'(1);
                end
                if (path.path_byte == CHAR_DOT && dot_reg == DOT_NONE)
                begin
                    dot_next = DOT_ONE;
                end
                else if (path.path_byte == CHAR_DOT && dot_reg == DOT_ONE)
                begin
                    dot_next = DOT_TWO;
                end
                else
                begin
                    dot_next = DOT_OTHER;
                end
            end
        end
    end

    assign final_err = (first_err_next == CERR_NONE) ? end_err : first_err_next;

    always_comb
    begin
        priority if (start_next)
        begin
            status_next = STATUS_EMPTY;
        end
        else if (PATH_CMP_W'(tot_next) > path_lim)
        begin
            status_next = STATUS_TOO_LONG;
        end
        else if (slash_first_next)
        begin
            status_next = STATUS_ABSOLUTE;
        end
        else if (forb_next)
        begin
            status_next = STATUS_FORBIDDEN;
        end
        else
        begin
            unique case (final_err)
                CERR_NONE:  status_next = STATUS_OK;
                CERR_EMPTY: status_next = STATUS_EMPTY_COMP;
                CERR_DOT:   status_next = STATUS_DOT_COMP;
                CERR_LONG:  status_next = STATUS_LONG_COMP;
                default:    status_next = STATUS_OK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_path_reg <= MAX_PATH_RESET;
            max_comp_reg <= MAX_COMP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_PATH: max_path_reg <= cfg_data[MAX_PATH_W-1:0];
                CFG_MAX_COMP: max_comp_reg <= cfg_data[MAX_COMP_W-1:0];
                default:      max_path_reg <= max_path_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tot_reg         <= '0;
            comp_reg        <= '0;
            dot_reg         <= DOT_NONE;
            start_reg       <= 1'b1;
            slash_first_reg <= 1'b0;
            forb_reg        <= 1'b0;
            first_err_reg   <= CERR_NONE;
        end
        else if (accept)
        begin
            if (path.last)
            begin
                tot_reg         <= '0;
                comp_reg        <= '0;
                dot_reg         <= DOT_NONE;
                start_reg       <= 1'b1;
                slash_first_reg <= 1'b0;
                forb_reg        <= 1'b0;
                first_err_reg   <= CERR_NONE;
            end
            else
            begin
                tot_reg         <= tot_next;
                comp_reg        <= comp_next;
                dot_reg         <= dot_next;
                start_reg       <= start_next;
                slash_first_reg <= slash_first_next;
                forb_reg        <= forb_next;
                first_err_reg   <= first_err_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && path.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && path.last)
        begin
            status_reg <= status_next;
        end
    end

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(accept && path.last))
        else $error("result raised without a last request");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && path.last |=> start_reg && tot_reg == '0 && comp_reg == '0
                                && first_err_reg == CERR_NONE)
        else $error("path state not cleared after last");

    a_start_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> tot_reg == '0 && !slash_first_reg && !forb_reg)
        else $error("bytes counted while at path start");

    a_counter_sat: assert property (@(posedge clk) disable iff (!rst_n)
        tot_reg <= TOT_SAT && comp_reg <= COMP_SAT)
        else $error("length counter beyond saturation");

endmodule
